// File: sv/vertex_transform_divide_macros.svh
// Assertion macros for the vertex transform block.
// Used by the divider and the top level; no other dependencies.
`ifndef VERTEX_TRANSFORM_DIVIDE_MACROS_SVH
`define VERTEX_TRANSFORM_DIVIDE_MACROS_SVH
`ifndef SYNTH
`define VTD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define VTD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define VTD_ASSERT_IMPL(label, clk, rst_n, prop)
`define VTD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: sv/vtd_pkg.sv
// Shared types and constants for the vertex transform block.
// No dependencies.
`default_nettype none
package vtd_pkg;
    localparam int DataWidth = 16;
    localparam int FracBits  = 8;
    localparam int SumWidth  = 2 * DataWidth + 2;
    localparam int NumWidth  = DataWidth + FracBits;
    localparam int QuoWidth  = NumWidth;
    localparam int Stages    = NumWidth;

    localparam logic [2:0] RegRowZero  = 3'd0;
    localparam logic [2:0] RegRowOne   = 3'd1;
    localparam logic [2:0] RegRowTwo   = 3'd2;
    localparam logic [2:0] RegRowThree = 3'd3;
    localparam logic [2:0] RegDivide   = 3'd4;

    localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
    localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
    localparam logic signed [DataWidth-1:0] OneVal = DataWidth'(1 << FracBits);

    typedef logic signed [DataWidth-1:0] data_t;

    // Flags that travel with a vertex along the divide pipe.
    typedef struct packed {
        logic valid;
        logic divide;
        logic sat;
        logic wz;
    } vtd_ctl_t;
endpackage
`default_nettype wire

// File: sv/vtd_divider.sv
// Pipelined restoring divider: three signed quotients by one shared divisor.
// Depends on vtd_pkg and the macros header.
`default_nettype none
`include "vertex_transform_divide_macros.svh"
module vtd_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vtd_pkg::vtd_ctl_t ctl_in,
    input  wire vtd_pkg::data_t   num_x,
    input  wire vtd_pkg::data_t   num_y,
    input  wire vtd_pkg::data_t   num_z,
    input  wire vtd_pkg::data_t   den,
    output vtd_pkg::vtd_ctl_t     ctl_out,
    output vtd_pkg::data_t        quo_x,
    output vtd_pkg::data_t        quo_y,
    output vtd_pkg::data_t        quo_z,
    output logic                  quo_sat
);
    localparam int NW = vtd_pkg::NumWidth;
    localparam int S  = vtd_pkg::Stages;

    // Per stage: magnitudes, remainders, quotient bits, signs.
    logic [NW-1:0]            mag_reg  [0:S][0:2];
    logic [NW-1:0]            rem_reg  [0:S][0:2];
    logic [NW-1:0]            quo_reg  [0:S][0:2];
    logic [2:0]               neg_reg  [0:S];
    logic [vtd_pkg::DataWidth-1:0] dmag_reg [0:S];
    vtd_pkg::vtd_ctl_t        ctl_reg  [0:S];
    vtd_pkg::data_t           raw_reg  [0:S][0:3];

    logic [NW-1:0]               num_ext [0:2];
    vtd_pkg::data_t              nums    [0:2];
    logic [vtd_pkg::DataWidth:0] den_abs;

    always_comb
    begin
        nums[0] = num_x;
        nums[1] = num_y;
        nums[2] = num_z;
        den_abs = den[vtd_pkg::DataWidth-1] ? (vtd_pkg::DataWidth+1)'(-$signed({den[15], den}))
                                            : {1'b0, den};
        for (int k = 0; k < 3; k++)
        begin
            num_ext[k] = nums[k][vtd_pkg::DataWidth-1]
                ? NW'(-$signed({nums[k], {vtd_pkg::FracBits{1'b0}}}))
                : {nums[k], {vtd_pkg::FracBits{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= S; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 0; s < S; s++)
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg[0] <= den_abs[vtd_pkg::DataWidth-1:0] | {vtd_pkg::DataWidth{den_abs[16]}};
        raw_reg[0][0] <= num_x;
        raw_reg[0][1] <= num_y;
        raw_reg[0][2] <= num_z;
        raw_reg[0][3] <= den;
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[0][k] <= num_ext[k];
            rem_reg[0][k] <= '0;
            quo_reg[0][k] <= '0;
            neg_reg[0][k] <= nums[k][vtd_pkg::DataWidth-1] ^ den[vtd_pkg::DataWidth-1];
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < S; s++)
    begin : g_stage
        logic [NW:0] trial [0:2];
        logic [NW:0] dfull;
        always_comb
        begin
            dfull = (raw_reg[s][3] == vtd_pkg::MinVal) ? (NW+1)'(1 << (vtd_pkg::DataWidth-1))
                                                      : (NW+1)'(dmag_reg[s]);
            for (int k = 0; k < 3; k++)
            begin
                trial[k] = {rem_reg[s][k], mag_reg[s][k][NW-1-s]};
            end
        end
        always_ff @(posedge clk)
        begin
            dmag_reg[s+1] <= dmag_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            raw_reg[s+1]  <= raw_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[s+1][k] <= mag_reg[s][k];
                if (trial[k] >= dfull)
                begin
                    rem_reg[s+1][k] <= NW'(trial[k] - dfull);
                    quo_reg[s+1][k] <= quo_reg[s][k] | (NW'(1) << (NW-1-s));
                end
                else
                begin
                    rem_reg[s+1][k] <= NW'(trial[k]);
                    quo_reg[s+1][k] <= quo_reg[s][k];
                end
            end
        end
    end

    // Sign and saturate, or pass through when the quotient is bypassed.
    vtd_pkg::data_t res [0:2];
    logic           sat_any;
    always_comb
    begin
        sat_any = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (neg_reg[S][k])
            begin
                if (quo_reg[S][k] > NW'(1 << (vtd_pkg::DataWidth-1)))
                begin
                    res[k] = vtd_pkg::MinVal;
                    sat_any = 1'b1;
                end
                else
                begin
                    res[k] = vtd_pkg::DataWidth'(-quo_reg[S][k]);
                end
            end
            else if (quo_reg[S][k] > NW'(vtd_pkg::MaxVal))
            begin
                res[k] = vtd_pkg::MaxVal;
                sat_any = 1'b1;
            end
            else
            begin
                res[k] = vtd_pkg::DataWidth'(quo_reg[S][k]);
            end
        end
    end

    logic use_div;
    assign use_div = ctl_reg[S].divide && !ctl_reg[S].wz;
    assign ctl_out = ctl_reg[S];
    assign quo_x   = use_div ? res[0] : raw_reg[S][0];
    assign quo_y   = use_div ? res[1] : raw_reg[S][1];
    assign quo_z   = use_div ? res[2] : raw_reg[S][2];
    assign quo_sat = use_div && sat_any;

    `VTD_ASSERT_IMPL(a_wz_only_div, clk, rst_n, ctl_out.wz |-> ctl_out.divide)
    `VTD_ASSERT_NEXT(a_valid_moves, clk, rst_n, ctl_in.valid, ctl_reg[0].valid)
    `VTD_ASSERT_IMPL(a_sat_needs_div, clk, rst_n, quo_sat |-> use_div)
endmodule
`default_nettype wire

// File: sv/vertex_transform_divide.sv
// Homogeneous 4x4 vertex transform with optional perspective divide.
// Accepts one request per cycle. The multiply/accumulate registers the request, products,
// sums and rounded result in turn; the divider resolves one bit per stage.
// busy is always low: the pipe never stalls since the receiver cannot hold results.
// Reset (asynchronous, active low) restores the identity matrix, disables divide
// and empties the pipe; data registers are not reset.
// Depends on vtd_pkg, vtd_divider and the macros header.
`default_nettype none
`include "vertex_transform_divide_macros.svh"
module vertex_transform_divide (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic signed [15:0] in_z,
    input  wire logic signed [15:0] in_w,
    output logic             done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [15:0] out_w,
    output logic             saturated,
    output logic             w_zero
);
    localparam int DW = vtd_pkg::DataWidth;
    localparam int SW = vtd_pkg::SumWidth;

    logic [63:0] row_reg [0:3];
    logic        divide_enable_reg;

    // Configuration registers; the user must write them only while the pipe is empty (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= 64'd256;
            row_reg[1] <= 64'd16777216;
            row_reg[2] <= 64'd1099511627776;
            row_reg[3] <= 64'd72057594037927936;
            divide_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vtd_pkg::RegRowZero:  row_reg[0] <= cfg_data;
                vtd_pkg::RegRowOne:   row_reg[1] <= cfg_data;
                vtd_pkg::RegRowTwo:   row_reg[2] <= cfg_data;
                vtd_pkg::RegRowThree: row_reg[3] <= cfg_data;
                vtd_pkg::RegDivide:   divide_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: register the request. Stage 2: sixteen products.
    // Stage 3: sums. Stage 4: round and saturate.
    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    vtd_pkg::data_t p1_reg [0:3];
    logic signed [2*DW-1:0] prod_reg [0:3][0:3];
    logic signed [SW-1:0]   sum_reg  [0:3];
    vtd_pkg::data_t r4_reg [0:3];
    logic   sat4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic signed [SW-1:0] rnd [0:3];
    vtd_pkg::data_t       clip_val [0:3];
    logic [3:0]           clip_hit;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // Adding half an LSB then flooring rounds ties toward plus infinity.
            rnd[i] = (sum_reg[i] + SW'(1 << (vtd_pkg::FracBits-1))) >>> vtd_pkg::FracBits;
            clip_hit[i] = 1'b1;
            if (rnd[i] > SW'(vtd_pkg::MaxVal))
            begin
                clip_val[i] = vtd_pkg::MaxVal;
            end
            else if (rnd[i] < SW'(vtd_pkg::MinVal))
            begin
                clip_val[i] = vtd_pkg::MinVal;
            end
            else
            begin
                clip_val[i] = DW'(rnd[i]);
                clip_hit[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg[0] <= in_x;
        p1_reg[1] <= in_y;
        p1_reg[2] <= in_z;
        p1_reg[3] <= in_w;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[i][j] <= $signed(row_reg[i][DW*j +: DW]) * p1_reg[j];
            end
            sum_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1])
                        + SW'(prod_reg[i][2]) + SW'(prod_reg[i][3]);
            r4_reg[i] <= clip_val[i];
        end
        sat4_reg <= |clip_hit;
    end

    vtd_pkg::vtd_ctl_t ctl4, ctl_out;
    vtd_pkg::data_t    qx, qy, qz;
    logic              qsat;
    always_comb
    begin
        ctl4.valid  = v4_reg;
        ctl4.divide = divide_enable_reg;
        ctl4.sat    = sat4_reg;
        ctl4.wz     = divide_enable_reg && (r4_reg[3] == '0);
    end

    vtd_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl4),
        .num_x   (r4_reg[0]),
        .num_y   (r4_reg[1]),
        .num_z   (r4_reg[2]),
        .den     (r4_reg[3]),
        .ctl_out (ctl_out),
        .quo_x   (qx),
        .quo_y   (qy),
        .quo_z   (qz),
        .quo_sat (qsat)
    );

    // Output register: the result is shown for exactly one cycle.
    vtd_pkg::data_t ow_raw_reg;
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x <= qx;
        out_y <= qy;
        out_z <= qz;
        out_w <= (ctl_out.divide && !ctl_out.wz) ? vtd_pkg::OneVal : ow_raw_reg;
        saturated <= ctl_out.sat | qsat;
        w_zero <= ctl_out.wz;
    end

    // The undivided w rides along outside the divider.
    vtd_pkg::data_t wline_reg [0:vtd_pkg::Stages];
    always_ff @(posedge clk)
    begin
        wline_reg[0] <= r4_reg[3];
        for (int s = 0; s < vtd_pkg::Stages; s++)
        begin
            wline_reg[s+1] <= wline_reg[s];
        end
    end
    assign ow_raw_reg = wline_reg[vtd_pkg::Stages];
    assign done = done_reg;

    `VTD_ASSERT_IMPL(a_never_busy, clk, rst_n, !busy)
    `VTD_ASSERT_NEXT(a_done_follows, clk, rst_n, ctl_out.valid, done)
    `VTD_ASSERT_NEXT(a_stage_flow, clk, rst_n, v3_reg, v4_reg)
    `VTD_ASSERT_IMPL(a_wz_out, clk, rst_n, (done && w_zero) |-> (out_w == '0))
endmodule
`default_nettype wire

// File: dv/tb_vertex_transform_divide.sv
// Testbench for the homogeneous 4x4 vertex transform with perspective divide.
// A directed table and then random bursts of points are checked against a built-in
// transform model; depends on vtd_pkg and the vertex_transform_divide RTL.
`default_nettype none
module tb_vertex_transform_divide;

    // One transformed point as the block reports it.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               sat;
        logic               wz;
    } point_t;

    // One row of the directed table: the point and, where it is obvious, the answer.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        bit                 known;
        point_t             answer;
    } vector_t;

    localparam logic signed [15:0] Lo = 16'sh8000;
    localparam logic signed [15:0] Hi = 16'sh7fff;
    localparam int                 Settle = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic signed [15:0] in_x, in_y, in_z, in_w;
    logic        done;
    logic signed [15:0] out_x, out_y, out_z, out_w;
    logic        saturated, w_zero;

    // The transform matrix and divide setting as the block should currently hold them.
    logic [63:0] matrix_rows [4];
    logic        divide_on;

    point_t  pending_points [$];
    int      mismatch_count;
    int      request_count;
    int      point_count;
    int      divide_zero_count;
    int      clip_count;

    vertex_transform_divide dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_w      (in_w),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .saturated (saturated),
        .w_zero    (w_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Saturates a wide value to 16-bit Q8.8 and raises the clip flag when it had to.
    function automatic logic signed [15:0] clamp16(input longint v, inout logic flag);
        if (v > 32767)
        begin
            flag = 1'b1;
            return Hi;
        end
        if (v < -32768)
        begin
            flag = 1'b1;
            return Lo;
        end
        return v[15:0];
    endfunction

    // Computes the transformed point from the current matrix and divide setting.
    // Sums are at most four 32-bit products, so a longint never overflows here;
    // the >>> is an arithmetic floor, and adding half a step gives ties upward.
    function automatic point_t transform_point(input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] pz,
                                               input logic signed [15:0] pw);
        longint  coord [4];
        longint  acc;
        longint  quotient;
        longint  lanes [4];
        logic    clipped;
        point_t  r;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        coord[3] = pw;
        clipped = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            acc = 0;
            for (int j = 0; j < 4; j++)
            begin
                acc += longint'($signed(matrix_rows[i][16*j +: 16])) * coord[j];
            end
            lanes[i] = clamp16((acc + 128) >>> 8, clipped);
        end
        r.wz = 1'b0;
        if (divide_on)
        begin
            if (lanes[3] == 0)
            begin
                r.wz = 1'b1;
            end
            else
            begin
                // SystemVerilog division truncates toward zero, as the block does.
                for (int i = 0; i < 3; i++)
                begin
                    quotient = (lanes[i] * 256) / lanes[3];
                    lanes[i] = clamp16(quotient, clipped);
                end
                lanes[3] = 256;
            end
        end
        r.x = lanes[0][15:0];
        r.y = lanes[1][15:0];
        r.z = lanes[2][15:0];
        r.w = lanes[3][15:0];
        r.sat = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH point %0d %s: got %0d, expected %0d", point_count, what, got, want);
    endtask

    // Writes one register while the block is idle, and updates the model's copy.
    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index == vtd_pkg::RegDivide)
        begin
            divide_on = value[0];
        end
        else if (index < vtd_pkg::RegDivide)
        begin
            matrix_rows[index] = value;
        end
    endtask

    task automatic load_matrix(input logic [63:0] r0, input logic [63:0] r1,
                               input logic [63:0] r2, input logic [63:0] r3,
                               input logic div);
        write_register(vtd_pkg::RegRowZero, r0);
        write_register(vtd_pkg::RegRowOne, r1);
        write_register(vtd_pkg::RegRowTwo, r2);
        write_register(vtd_pkg::RegRowThree, r3);
        write_register(vtd_pkg::RegDivide, {63'd0, div});
    endtask

    // Waits for every queued result and then for the pipe to drain completely.
    task automatic drain_pipe();
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (Settle) @(posedge clk);
    endtask

    // Presents one request; with known set, the typed answer is queued instead of the model's.
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] pz, input logic signed [15:0] pw,
                              input bit known, input point_t answer);
        start <= 1'b1;
        in_x  <= px;
        in_y  <= py;
        in_z  <= pz;
        in_w  <= pw;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_points.push_back(known ? answer : transform_point(px, py, pz, pw));
        request_count++;
    endtask

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 7))
            0: return Lo;
            1: return Hi;
            2: return 16'sd0;
            3, 4: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly modest coefficients so the divide path stays interesting, with full-range ones.
    function automatic logic [63:0] random_row();
        logic [63:0] row;
        for (int j = 0; j < 4; j++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                row[16*j +: 16] = 16'($urandom);
            end
            else
            begin
                row[16*j +: 16] = 16'($signed($urandom_range(0, 1023)) - 512);
            end
        end
        return row;
    endfunction

    // Checks each result in the cycle its strobe marks it, against the oldest request.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && done)
        begin
            point_count++;
            if (pending_points.size() == 0)
            begin
                report_mismatch("done with no request outstanding", 1, 0);
            end
            else
            begin
                want = pending_points.pop_front();
                if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
                if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
                if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
                if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
                if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
                if (w_zero !== want.wz) report_mismatch("w_zero", w_zero, want.wz);
                if (want.wz) divide_zero_count++;
                if (want.sat) clip_count++;
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d results still outstanding", pending_points.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        vector_t directed [$];
        point_t  none;
        int      burst;
        int      gap;
        none = '{x: 0, y: 0, z: 0, w: 0, sat: 0, wz: 0};

        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = vtd_pkg::RegRowZero;
        cfg_data  = '0;
        in_x      = '0;
        in_y      = '0;
        in_z      = '0;
        in_w      = '0;
        mismatch_count    = 0;
        request_count     = 0;
        point_count       = 0;
        divide_zero_count = 0;
        clip_count        = 0;
        matrix_rows[0] = 64'd256;
        matrix_rows[1] = 64'd16777216;
        matrix_rows[2] = 64'd1099511627776;
        matrix_rows[3] = 64'd72057594037927936;
        divide_on      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the matrix is the identity and divide is off: points pass unchanged.
        directed.push_back('{1, 2, 3, 256, 1, '{1, 2, 3, 256, 0, 0}});
        directed.push_back('{Hi, Lo, Hi, Lo, 1, '{Hi, Lo, Hi, Lo, 0, 0}});
        directed.push_back('{0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}});
        directed.push_back('{-1, 16'sh5555, 16'sh2aaa, -2, 1, '{-1, 16'sh5555, 16'sh2aaa, -2, 0, 0}});
        foreach (directed[k])
        begin
            send_point(directed[k].x, directed[k].y, directed[k].z, directed[k].w,
                       directed[k].known, directed[k].answer);
        end
        start <= 1'b0;
        drain_pipe();

        // Identity with divide on: a zero w raises the flag and passes the point through,
        // while w of 1.0 leaves x, y and z as they were.
        write_register(vtd_pkg::RegDivide, 64'd1);
        directed.delete();
        directed.push_back('{100, -200, 300, 0, 1, '{100, -200, 300, 0, 0, 1}});
        directed.push_back('{100, -200, 300, 256, 1, '{100, -200, 300, 256, 0, 0}});
        directed.push_back('{Hi, 0, 0, 128, 1, '{Hi, 0, 0, 256, 1, 0}});
        directed.push_back('{Lo, 5, -7, -256, 1, '{Hi, -5, 7, 256, 1, 0}});
        directed.push_back('{Lo, Lo, Lo, Lo, 0, none});
        directed.push_back('{Hi, Hi, Hi, Hi, 0, none});
        directed.push_back('{77, -77, 1, 3, 0, none});
        foreach (directed[k])
        begin
            send_point(directed[k].x, directed[k].y, directed[k].z, directed[k].w,
                       directed[k].known, directed[k].answer);
        end
        start <= 1'b0;
        drain_pipe();

        // Extreme coefficients: rows zero to two at the most negative or most positive value,
        // row three at one half: the accumulators saturate and rounding ties go both ways.
        load_matrix({4{Lo}}, {4{Hi}}, {Hi, Lo, Hi, Lo}, {16'h0080, 16'h0080, 16'h0080, 16'h0080},
                    1'b0);
        directed.delete();
        directed.push_back('{Lo, Lo, Lo, Lo, 0, none});
        directed.push_back('{Hi, Hi, Hi, Hi, 0, none});
        directed.push_back('{1, 0, 0, 0, 0, none});
        directed.push_back('{-1, 0, 0, 0, 0, none});
        directed.push_back('{3, -1, 1, -3, 0, none});
        foreach (directed[k])
        begin
            send_point(directed[k].x, directed[k].y, directed[k].z, directed[k].w,
                       directed[k].known, directed[k].answer);
        end
        start <= 1'b0;
        drain_pipe();

        // Random phases: a fresh matrix and divide setting each time, then bursts of points
        // with random gaps, so idle cycles land at every depth of the pipe.
        for (int phase = 0; phase < 11; phase++)
        begin
            if (phase == 10)
            begin
                load_matrix(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
            end
            else
            begin
                load_matrix(random_row(), random_row(), random_row(), random_row(),
                            phase % 3 != 2);
            end
            for (int n = 0; n < 100; n += burst)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst; b++)
                begin
                    send_point(random_coord(), random_coord(), random_coord(), random_coord(),
                               0, none);
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                // Now and then hold off until every outstanding result has come back.
                if ($urandom_range(0, 15) == 0)
                begin
                    start <= 1'b0;
                    while (pending_points.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            start <= 1'b0;
            drain_pipe();
        end

        $display("Sent %0d points over 14 matrix settings; %0d clipped, %0d hit zero w.",
                 request_count, clip_count, divide_zero_count);
        if (mismatch_count == 0 && pending_points.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/vtd_pkg.sv
sv/vtd_divider.sv
sv/vertex_transform_divide.sv
dv/tb_vertex_transform_divide.sv
